// ----- hdl/zc_pkg.sv -----
// shared types, constants and key update functions for the zip traditional decryptor
`default_nettype none
package zc_pkg;

    localparam int unsigned HEADER_BYTES = 12;
    localparam int unsigned HDR_CNT_W    = 4;

    localparam logic [31:0] KEY_A_INIT = 32'd305419896;
    localparam logic [31:0] KEY_B_INIT = 32'd591751049;
    localparam logic [31:0] KEY_C_INIT = 32'd878082192;
    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;

    localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_CNT_W'(HEADER_BYTES - 1);

    typedef enum logic [1:0] {
        CMD_RESTART  = 2'd0,
        CMD_PASSWORD = 2'd1,
        CMD_CIPHER   = 2'd2,
        CMD_UNUSED   = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [31:0] key_a;
        logic [31:0] key_b;
        logic [31:0] key_c;
    } keys_t;

    typedef struct packed {
        logic [7:0] plain_byte;
        logic       is_header;
        logic       check_done;
        logic       bad_password;
    } result_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] r;
        r = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            if (r[0])
                r = (r >> 1) ^ CRC_POLY;
            else
                r = r >> 1;
        end
        return r;
    endfunction

    // multiply by 134775813 (0x08088405) as a sum of shifted terms
    function automatic logic [31:0] lcg_mul(input logic [31:0] x);
        return x + (x << 2) + (x << 10) + (x << 15) + (x << 19) + (x << 27);
    endfunction

    function automatic keys_t update_keys(input keys_t k, input logic [7:0] b);
        keys_t n;
        n.key_a = crc_byte(k.key_a, b);
        n.key_b = lcg_mul(k.key_b + {24'd0, n.key_a[7:0]}) + 32'd1;
        n.key_c = crc_byte(k.key_c, n.key_b[31:24]);
        return n;
    endfunction

    function automatic logic [7:0] keystream_byte(input logic [31:0] key_c);
        logic [15:0] t;
        logic [15:0] p;
        t = {key_c[15:2], 1'b1, key_c[0]};
        p = t * (t ^ 16'd1);
        return p[15:8];
    endfunction

endpackage
`default_nettype wire

// ----- hdl/zc_if.sv -----
// stream and configuration channel interfaces
`default_nettype none
interface zc_in_if;
    import zc_pkg::*;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] data_byte;
    logic       burst_end;
    modport source (output valid, command, data_byte, burst_end, input ready);
    modport sink (input valid, command, data_byte, burst_end, output ready);
endinterface

interface zc_out_if;
    import zc_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] plain_byte;
    logic       is_header;
    logic       check_done;
    logic       bad_password;
    logic       burst_end_out;
    modport source (output valid, plain_byte, is_header, check_done, bad_password,
                    burst_end_out, input ready);
    modport sink (input valid, plain_byte, is_header, check_done, bad_password,
                  burst_end_out, output ready);
endinterface

interface zc_cfg_if;
    import zc_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- hdl/zip_traditional_decrypt.sv -----
// top level of the zip traditional (pkware) byte-wise decryptor
// usage:
//   cipher_in carries one word per item: command (restart, password byte,
//   cipher byte), data_byte and burst_end
//   plain_out returns exactly one word per accepted item, in order, with
//   the decrypted byte, header flags, check result and the burst_end copy
//   cfg writes the expected check byte; write it only while idle
// timing:
//   a result word appears one cycle after its item is accepted
//   one item per cycle sustained; the key update and keystream of an item
//   finish in the same cycle, through one 16x16 keystream multiply
// reset:
//   keys load their initial constants, the header count and check byte clear
// stall:
//   a held result blocks intake only while plain_out.ready is low and the
//   output register is full; an item is taken in the cycle the word leaves
`default_nettype none
module zip_traditional_decrypt
(
    input  wire logic clk,
    input  wire logic rst_n,
    zc_in_if.sink     cipher_in,
    zc_out_if.source  plain_out,
    zc_cfg_if.sink    cfg
);
    import zc_pkg::*;

    keys_t                keys_reg;
    keys_t                keys_next;
    logic [HDR_CNT_W-1:0] hdr_cnt_reg;
    logic [HDR_CNT_W-1:0] hdr_cnt_next;
    logic [7:0]           expected_check_reg;
    logic                 out_valid_reg;
    result_t              result_reg;
    result_t              result_next;
    logic                 burst_end_reg;
    logic                 accept;

    assign cfg.ready       = 1'b1;
    assign cipher_in.ready = !out_valid_reg || plain_out.ready;
    assign accept          = cipher_in.valid && cipher_in.ready;

    zc_step u_step
    (
        .keys           (keys_reg),
        .hdr_cnt        (hdr_cnt_reg),
        .command        (cipher_in.command),
        .data_byte      (cipher_in.data_byte),
        .expected_check (expected_check_reg),
        .keys_next      (keys_next),
        .hdr_cnt_next   (hdr_cnt_next),
        .result         (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keys_reg.key_a     <= KEY_A_INIT;
            keys_reg.key_b     <= KEY_B_INIT;
            keys_reg.key_c     <= KEY_C_INIT;
            hdr_cnt_reg        <= '0;
            expected_check_reg <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
                expected_check_reg <= cfg.data;
            if (accept)
            begin
                keys_reg      <= keys_next;
                hdr_cnt_reg   <= hdr_cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (plain_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg    <= result_next;
            burst_end_reg <= cipher_in.burst_end;
        end
    end

    assign plain_out.valid         = out_valid_reg;
    assign plain_out.plain_byte    = result_reg.plain_byte;
    assign plain_out.is_header     = result_reg.is_header;
    assign plain_out.check_done    = result_reg.check_done;
    assign plain_out.bad_password  = result_reg.bad_password;
    assign plain_out.burst_end_out = burst_end_reg;

endmodule
`default_nettype wire

// ----- hdl/zc_step.sv -----
// one decryptor step: key update, keystream xor and header check
`default_nettype none
module zc_step
(
    input  wire zc_pkg::keys_t                 keys,
    input  wire logic [zc_pkg::HDR_CNT_W-1:0]  hdr_cnt,
    input  wire logic [1:0]                    command,
    input  wire logic [7:0]                    data_byte,
    input  wire logic [7:0]                    expected_check,
    output zc_pkg::keys_t                      keys_next,
    output logic [zc_pkg::HDR_CNT_W-1:0]       hdr_cnt_next,
    output zc_pkg::result_t                    result
);
    import zc_pkg::*;

    logic [7:0] plain;
    logic       in_header;

    assign plain     = data_byte ^ keystream_byte(keys.key_c);
    assign in_header = hdr_cnt < HDR_CNT_W'(HEADER_BYTES);

    always_comb
    begin
        keys_next    = keys;
        hdr_cnt_next = hdr_cnt;
        result       = '0;
        unique case (cmd_t'(command))
            CMD_RESTART:
            begin
                keys_next.key_a = KEY_A_INIT;
                keys_next.key_b = KEY_B_INIT;
                keys_next.key_c = KEY_C_INIT;
                hdr_cnt_next    = '0;
            end
            CMD_PASSWORD:
            begin
                keys_next = update_keys(keys, data_byte);
            end
            CMD_CIPHER:
            begin
                keys_next         = update_keys(keys, plain);
                result.plain_byte = plain;
                if (in_header)
                begin
                    result.is_header = 1'b1;
                    hdr_cnt_next     = hdr_cnt + HDR_CNT_W'(1);
                    if (hdr_cnt == HDR_LAST)
                    begin
                        result.check_done   = 1'b1;
                        result.bad_password = (plain != 8'd0) && (plain != expected_check);
                    end
                end
            end
            default:
            begin
                keys_next = keys;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
// self-checking testbench for the zip traditional decryptor
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import zc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam logic [31:0] CRC_KEY_INIT    = 32'h12345678;
    localparam logic [31:0] MIX_KEY_INIT    = 32'h23456789;
    localparam logic [31:0] STREAM_KEY_INIT = 32'h34567890;
    localparam logic [31:0] MIX_MUL         = 32'd134775813;
    localparam logic [31:0] REFLECTED_POLY  = 32'hEDB88320;
    localparam logic [3:0]  HEADER_LEN      = 4'd12;

    typedef struct packed {
        logic [7:0] plain_byte;
        logic       is_header;
        logic       check_done;
        logic       bad_password;
        logic       burst_end;
    } plain_word_t;

    logic clk;
    logic rst_n;

    zc_in_if  cipher_ch ();
    zc_out_if plain_ch ();
    zc_cfg_if cfg_ch ();

    zip_traditional_decrypt uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cipher_in (cipher_ch),
        .plain_out (plain_ch),
        .cfg       (cfg_ch)
    );

    logic [31:0] crc_key;
    logic [31:0] mix_key;
    logic [31:0] stream_key;
    logic [3:0]  header_count;
    logic [7:0]  check_byte;

    plain_word_t expected_words[$];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          items_sent;
    int          words_checked = 0;
    int          header_checks;
    int          bad_flags;
    int          error_count = 0;
    int          cycle_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] crc8_step(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] r;
        r = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            if (r[0])
                r = (r >> 1) ^ REFLECTED_POLY;
            else
                r = r >> 1;
        end
        return r;
    endfunction

    function automatic logic [7:0] keystream_now();
        logic [15:0] t;
        logic [31:0] p;
        t = stream_key[15:0] | 16'h0002;
        p = {16'd0, t} * {16'd0, t ^ 16'h0001};
        return p[15:8];
    endfunction

    function automatic void mix_in_byte(input logic [7:0] b);
        crc_key    = crc8_step(crc_key, b);
        mix_key    = (mix_key + {24'd0, crc_key[7:0]}) * MIX_MUL + 32'd1;
        stream_key = crc8_step(stream_key, mix_key[31:24]);
    endfunction

    // cipher byte that decrypts to the wanted plain byte from the current keys
    function automatic logic [7:0] cipher_for(input logic [7:0] plain);
        return plain ^ keystream_now();
    endfunction

    function automatic plain_word_t decrypt_word(input cmd_t cmd, input logic [7:0] data,
                                                 input logic burst);
        plain_word_t w;
        w = '0;
        w.burst_end = burst;
        case (cmd)
            CMD_RESTART:
            begin
                crc_key      = CRC_KEY_INIT;
                mix_key      = MIX_KEY_INIT;
                stream_key   = STREAM_KEY_INIT;
                header_count = 4'd0;
            end
            CMD_PASSWORD:
                mix_in_byte(data);
            CMD_CIPHER:
            begin
                w.plain_byte = data ^ keystream_now();
                mix_in_byte(w.plain_byte);
                if (header_count < HEADER_LEN)
                begin
                    w.is_header  = 1'b1;
                    header_count = header_count + 4'd1;
                    if (header_count == HEADER_LEN)
                    begin
                        w.check_done   = 1'b1;
                        w.bad_password = (w.plain_byte != 8'd0) && (w.plain_byte != check_byte);
                    end
                end
            end
            default:
            begin
            end
        endcase
        return w;
    endfunction

    task automatic send_word(input cmd_t cmd, input logic [7:0] data, input logic burst);
        plain_word_t w;
        while ($urandom_range(99) < send_idle_pct)
        begin
            cipher_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cipher_ch.valid     <= 1'b1;
        cipher_ch.command   <= cmd;
        cipher_ch.data_byte <= data;
        cipher_ch.burst_end <= burst;
        do
            @(posedge clk);
        while (cipher_ch.ready !== 1'b1);
        w = decrypt_word(cmd, data, burst);
        header_checks += w.check_done;
        bad_flags     += w.bad_password;
        expected_words.push_back(w);
        items_sent++;
    endtask

    task automatic send_cipher(input logic burst);
        logic [7:0] data;
        data = 8'($urandom);
        if (header_count == HEADER_LEN - 4'd1)
        begin
            case ($urandom_range(2))
                0: data = cipher_for(8'd0);
                1: data = cipher_for(check_byte);
                default: data = 8'($urandom);
            endcase
        end
        send_word(CMD_CIPHER, data, burst);
    endtask

    task automatic drain();
        cipher_ch.valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_check(input logic [7:0] value);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        check_byte = value;
        @(posedge clk);
    endtask

    task automatic test_reset_keys();
        write_check(8'hA5);
        send_word(CMD_CIPHER, 8'h00, 1'b1);
        send_word(CMD_CIPHER, 8'hFF, 1'b0);
    endtask

    task automatic test_unused_command();
        send_word(CMD_UNUSED, 8'hFF, 1'b1);
        send_word(CMD_UNUSED, 8'h00, 1'b0);
    endtask

    task automatic test_zero_check_passes();
        send_word(CMD_RESTART, 8'hFF, 1'b0);
        send_word(CMD_PASSWORD, 8'h00, 1'b0);
        send_word(CMD_PASSWORD, 8'hFF, 1'b1);
        for (int i = 0; i < 11; i++)
            send_word(CMD_CIPHER, (i % 2) ? 8'hFF : 8'h00, i[0]);
        send_word(CMD_CIPHER, cipher_for(8'd0), 1'b1);
        send_word(CMD_CIPHER, 8'h3C, 1'b0);
    endtask

    task automatic test_password_after_cipher();
        send_word(CMD_PASSWORD, 8'h5A, 1'b0);
        send_word(CMD_CIPHER, 8'hC3, 1'b1);
    endtask

    task automatic test_restart_keeps_check();
        send_word(CMD_RESTART, 8'h00, 1'b1);
        send_word(CMD_CIPHER, 8'h81, 1'b0);
        drain();
    endtask

    task automatic random_items(input int count);
        int target;
        int pw_len;
        int n_cipher;
        target = items_sent + count;
        while (items_sent < target)
        begin
            if ($urandom_range(9) == 0)
                send_word(cmd_t'($urandom_range(3)), 8'($urandom), 1'($urandom_range(1)));
            else
            begin
                if ($urandom_range(9) != 0)
                    send_word(CMD_RESTART, 8'($urandom), 1'($urandom_range(1)));
                pw_len = $urandom_range(1, 10);
                for (int i = 0; i < pw_len; i++)
                    send_word(CMD_PASSWORD, 8'($urandom), 1'($urandom_range(1)));
                n_cipher = $urandom_range(1, 24);
                for (int i = 0; i < n_cipher; i++)
                begin
                    if ($urandom_range(15) == 0)
                        send_word(CMD_PASSWORD, 8'($urandom), 1'($urandom_range(1)));
                    send_cipher(1'($urandom_range(1)));
                end
            end
        end
    endtask

    task automatic test_random_phase(input int send_pct, input int recv_pct,
                                     input logic [7:0] first_check, input int count);
        write_check(first_check);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        random_items(count / 2);
        write_check(8'($urandom));
        random_items(count - count / 2);
        drain();
    endtask

    always @(posedge clk)
        plain_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        plain_word_t w;
        if (rst_n && plain_ch.valid === 1'b1 && plain_ch.ready === 1'b1)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected result word: plain_byte %0h", plain_ch.plain_byte);
                error_count++;
            end
            else
            begin
                w = expected_words.pop_front();
                words_checked++;
                if (plain_ch.plain_byte !== w.plain_byte)
                begin
                    $error("plain_byte: expected %0h, got %0h", w.plain_byte, plain_ch.plain_byte);
                    error_count++;
                end
                if (plain_ch.is_header !== w.is_header)
                begin
                    $error("is_header: expected %0b, got %0b", w.is_header, plain_ch.is_header);
                    error_count++;
                end
                if (plain_ch.check_done !== w.check_done)
                begin
                    $error("check_done: expected %0b, got %0b", w.check_done, plain_ch.check_done);
                    error_count++;
                end
                if (plain_ch.bad_password !== w.bad_password)
                begin
                    $error("bad_password: expected %0b, got %0b", w.bad_password,
                           plain_ch.bad_password);
                    error_count++;
                end
                if (plain_ch.burst_end_out !== w.burst_end)
                begin
                    $error("burst_end_out: expected %0b, got %0b", w.burst_end,
                           plain_ch.burst_end_out);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                     expected_words.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        rst_n               <= 1'b0;
        cipher_ch.valid     <= 1'b0;
        cipher_ch.command   <= CMD_RESTART;
        cipher_ch.data_byte <= 8'd0;
        cipher_ch.burst_end <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.data         <= 8'd0;
        crc_key       = CRC_KEY_INIT;
        mix_key       = MIX_KEY_INIT;
        stream_key    = STREAM_KEY_INIT;
        header_count  = 4'd0;
        check_byte    = 8'd0;
        send_idle_pct = 33;
        recv_idle_pct = 61;
        items_sent    = 0;
        header_checks = 0;
        bad_flags     = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_keys();
        test_unused_command();
        test_zero_check_passes();
        test_password_after_cipher();
        test_restart_keeps_check();
        test_random_phase(33, 61, 8'h00, 650);
        test_random_phase(61, 33, 8'hFF, 650);
        test_random_phase(0, 0, 8'($urandom), 600);

        drain();
        $display("%0d items sent, %0d result words checked in %0d cycles", items_sent,
                 words_checked, cycle_count);
        $display("%0d header checks predicted, %0d of them flagged bad", header_checks,
                 bad_flags);
        if (error_count == 0 && expected_words.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
`default_nettype wire

// ----- files.f -----
hdl/zc_pkg.sv
hdl/zc_if.sv
hdl/zc_step.sv
hdl/zip_traditional_decrypt.sv
dv/testbench.sv
